/* hdl/mrt_pkg.sv */
package mrt_pkg;

   typedef enum logic [1:0] {
      ACT_ADD        = 2'd0,
      ACT_FIND_NUM   = 2'd1,
      ACT_FIND_RANGE = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXISTS    = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PICK,
      S_RESULT
   } back_state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] region_number;
      logic [63:0] region_length;
      logic [63:0] physical_base;
      logic [31:0] access_flags;
      logic [63:0] query_offset;
      logic [63:0] query_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_number;
      logic [63:0] found_length;
      logic [63:0] found_physical;
      logic [31:0] found_flags;
      logic [63:0] found_offset;
   } rsp_type;

   // Classified command as it travels from the front end to the table engine.
   typedef struct packed {
      action_type  op;
      logic [31:0] number;
      logic [63:0] length;
      logic [63:0] physical;
      logic [31:0] flags;
      logic [63:0] query_offset;
      logic [63:0] query_end;
      logic [63:0] span;
   } cmd_type;

   typedef struct packed {
      logic [31:0] number;
      logic [63:0] length;
      logic [63:0] physical;
      logic [31:0] flags;
      logic [63:0] offset;
   } payload_type;

endpackage

/* hdl/mrt_front.sv */
module mrt_front #(
   parameter int PAGE_BYTES = 4096
) (
   input  logic             req_valid,
   output logic             req_stall,
   input  mrt_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output mrt_pkg::cmd_type q_cmd
);
   import mrt_pkg::*;

   // PAGE_BYTES is to be a power of two (the block does not enforce it), so rounding up is an add and a mask.
   localparam logic [63:0] PAGE_MASK = 64'(PAGE_BYTES - 1);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.op           = action_type'(req_data.action);
      q_cmd.number       = req_data.region_number;
      q_cmd.length       = req_data.region_length;
      q_cmd.physical     = req_data.physical_base;
      q_cmd.flags        = req_data.access_flags;
      q_cmd.query_offset = req_data.query_offset;
      q_cmd.query_end    = req_data.query_offset + req_data.query_length;
      q_cmd.span         = (req_data.region_length + PAGE_MASK) & ~PAGE_MASK;
   end

endmodule

/* hdl/mrt_queue.sv */
module mrt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mrt_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mrt_pkg::cmd_type head
);
   import mrt_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/mrt_back.sv */
module mrt_back #(
   parameter int MAX_REGIONS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  mrt_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mrt_pkg::rsp_type rsp_data
);
   import mrt_pkg::*;

   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_REGIONS);

   back_state_type state_ff, state_in;

   // Search keys live in flops so every row compares in parallel; the rest
   // of each entry sits in a memory read at the winning row.
   logic [31:0]      key_number_ff [MAX_REGIONS];
   logic [63:0]      key_start_ff  [MAX_REGIONS];
   logic [63:0]      key_end_ff    [MAX_REGIONS];
   payload_type      entry_mem     [MAX_REGIONS];
   payload_type      rd_data_ff;

   logic [CNT_W-1:0] count_ff;
   logic [63:0]      cursor_ff;

   cmd_type          cmd_ff;
   logic [MAX_REGIONS-1:0] hit_ff, hit_in;
   status_type       status_ff, status_in;
   logic             from_mem_ff;
   logic [63:0]      add_offset_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_in;

   logic [IDX_W-1:0] sel_idx;
   logic [IDX_W-1:0] wr_idx;
   logic             any_hit;
   logic             table_full;
   logic             add_ok;
   logic             load_rsp;
   payload_type      wr_payload;

   // Row compare against the command at the head of the queue.
   always_comb begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
         if (CNT_W'(i) >= count_ff) begin
            hit_in[i] = 1'b0;
         end else if (q_head.op == ACT_FIND_RANGE) begin
            hit_in[i] = (key_start_ff[i] <= q_head.query_offset) &&
                        (key_end_ff[i] >= q_head.query_end);
         end else begin
            hit_in[i] = (key_number_ff[i] == q_head.number);
         end
      end
   end

   // The newest matching row wins; numbers are unique so that order only
   // matters for range lookups.
   always_comb begin
      sel_idx = '0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
         if (hit_ff[i]) begin
            sel_idx = IDX_W'(i);
         end
      end
   end

   assign any_hit    = |hit_ff;
   assign table_full = (count_ff == FULL_COUNT);
   assign wr_idx     = count_ff[IDX_W-1:0];

   always_comb begin
      unique case (cmd_ff.op)
         ACT_ADD: begin
            if (any_hit) begin
               status_in = ST_EXISTS;
            end else if (table_full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_OK;
            end
         end
         ACT_FIND_NUM, ACT_FIND_RANGE: begin
            status_in = any_hit ? ST_OK : ST_NOT_FOUND;
         end
         ACT_NONE: begin
            status_in = ST_NOT_FOUND;
         end
      endcase
   end

   assign add_ok = (state_ff == S_PICK) && (cmd_ff.op == ACT_ADD) && (status_in == ST_OK);

   always_comb begin
      wr_payload.number   = cmd_ff.number;
      wr_payload.length   = cmd_ff.length;
      wr_payload.physical = cmd_ff.physical;
      wr_payload.flags    = cmd_ff.flags;
      wr_payload.offset   = cursor_ff;
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = status_ff;
      if (status_ff == ST_OK) begin
         if (from_mem_ff) begin
            rsp_in.found_number   = rd_data_ff.number;
            rsp_in.found_length   = rd_data_ff.length;
            rsp_in.found_physical = rd_data_ff.physical;
            rsp_in.found_flags    = rd_data_ff.flags;
            rsp_in.found_offset   = rd_data_ff.offset;
         end else begin
            rsp_in.found_number   = cmd_ff.number;
            rsp_in.found_length   = cmd_ff.length;
            rsp_in.found_physical = cmd_ff.physical;
            rsp_in.found_flags    = cmd_ff.flags;
            rsp_in.found_offset   = add_offset_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (add_ok) begin
            count_ff  <= count_ff + 1'b1;
            cursor_ff <= cursor_ff + cmd_ff.span;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_head;
         hit_ff <= hit_in;
      end
      if (state_ff == S_PICK) begin
         status_ff     <= status_in;
         from_mem_ff   <= (cmd_ff.op != ACT_ADD);
         add_offset_ff <= cursor_ff;
      end
      if (add_ok) begin
         key_number_ff[wr_idx] <= cmd_ff.number;
         key_start_ff[wr_idx]  <= cursor_ff;
         key_end_ff[wr_idx]    <= cursor_ff + cmd_ff.length;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (add_ok) begin
         entry_mem[wr_idx] <= wr_payload;
      end
      if (state_ff == S_PICK) begin
         rd_data_ff <= entry_mem[sel_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/mmio_region_table_top.sv */
// The table engine takes each request through compare, select/read and output steps and
// works on one request at a time; a two-entry queue lets new requests land early, while
// the engine is still busy with an earlier one.
// Reset (synchronous) empties the table, zeroes the offset cursor, drains the
// queue and drops the output valid; stale entry contents are hidden by the count.
module mmio_region_table_top #(
   parameter int MAX_REGIONS = 16,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mrt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mrt_pkg::rsp_type rsp_data
);
   import mrt_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;

   mrt_front #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   mrt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(push_cmd),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head    (head_cmd)
   );

   mrt_back #(
      .MAX_REGIONS(MAX_REGIONS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (head_cmd),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

/* hdl/mrt_checker.sv */
module mrt_checker #(
   parameter int PAGE_BYTES = 4096
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input mrt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mrt_pkg::rsp_type rsp_data
);
   import mrt_pkg::*;

   localparam logic [63:0] PAGE_MASK = 64'(PAGE_BYTES - 1);

   // A stalled result transfer keeps its valid and its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A failed request carries nothing but its status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |->
         (rsp_data.found_number == '0) && (rsp_data.found_length == '0) &&
         (rsp_data.found_physical == '0) && (rsp_data.found_flags == '0) &&
         (rsp_data.found_offset == '0))
      else $error("failed result carries entry data");

   // Offsets are sums of page-rounded lengths, so they stay page aligned.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_OK) |->
         ((rsp_data.found_offset & PAGE_MASK) == '0))
      else $error("entry offset not page aligned");

   // A stalled request transfer keeps its valid and its contents.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

endmodule

bind mmio_region_table_top mrt_checker #(
   .PAGE_BYTES(PAGE_BYTES)
) u_mrt_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

/* bench/mmio_region_table_top_tb.sv */
`timescale 1ns / 100ps

module mmio_region_table_top_tb;
   import mrt_pkg::*;

   localparam int MAX_ENTRIES = 16;
   localparam logic [63:0] PAGE = 64'd4096;
   localparam int STALL_LIMIT = 4000;

   // Mirror of the region table, fed by every accepted request.
   class region_scoreboard;
      logic [31:0] tbl_number [MAX_ENTRIES];
      logic [63:0] tbl_length [MAX_ENTRIES];
      logic [63:0] tbl_physical [MAX_ENTRIES];
      logic [31:0] tbl_flags [MAX_ENTRIES];
      logic [63:0] tbl_offset [MAX_ENTRIES];
      int unsigned used;
      logic [63:0] cursor;
      rsp_type predicted_rsp [$];
      int unsigned error_count;

      function new();
         used = 0;
         cursor = '0;
         error_count = 0;
      endfunction

      function logic [63:0] page_round(logic [63:0] x);
         logic [63:0] rem;
         rem = x % PAGE;
         if (rem == 0) return x;
         return x + (PAGE - rem);
      endfunction

      function int slot_of_number(logic [31:0] num);
         for (int i = 0; i < used; i++) begin
            if (tbl_number[i] == num) return i;
         end
         return -1;
      endfunction

      function rsp_type entry_result(int i);
         rsp_type res;
         res.status = ST_OK;
         res.found_number = tbl_number[i];
         res.found_length = tbl_length[i];
         res.found_physical = tbl_physical[i];
         res.found_flags = tbl_flags[i];
         res.found_offset = tbl_offset[i];
         return res;
      endfunction

      function void note_request(req_type r);
         rsp_type res;
         int slot;
         logic [63:0] q_end;
         res = '0;
         res.status = ST_NOT_FOUND;
         case (action_type'(r.action))
            ACT_ADD: begin
               slot = slot_of_number(r.region_number);
               // A duplicate number wins over a full table.
               if (slot >= 0) begin
                  res.status = ST_EXISTS;
               end else if (used >= MAX_ENTRIES) begin
                  res.status = ST_FULL;
               end else begin
                  tbl_number[used] = r.region_number;
                  tbl_length[used] = r.region_length;
                  tbl_physical[used] = r.physical_base;
                  tbl_flags[used] = r.access_flags;
                  tbl_offset[used] = cursor;
                  cursor = cursor + page_round(r.region_length);
                  res = entry_result(used);
                  used++;
               end
            end
            ACT_FIND_NUM: begin
               slot = slot_of_number(r.region_number);
               if (slot >= 0) res = entry_result(slot);
            end
            ACT_FIND_RANGE: begin
               q_end = r.query_offset + r.query_length;
               // Newest entry first; sums wrap at 64 bits.
               for (int i = int'(used) - 1; i >= 0; i--) begin
                  if (res.status == ST_NOT_FOUND && tbl_offset[i] <= r.query_offset &&
                      tbl_offset[i] + tbl_length[i] >= q_end) begin
                     res = entry_result(i);
                  end
               end
            end
            default: begin
            end
         endcase
         predicted_rsp.push_back(res);
      endfunction

      task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
         $display("%0t: bad %s, expected %h, got %h", $time, what, want, got);
         error_count++;
      endtask

      task compare_field(string what, logic [63:0] want, logic [63:0] got);
         if (got !== want) report_mismatch(what, want, got);
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (predicted_rsp.size() == 0) begin
            report_mismatch("response transfer with nothing outstanding", '0, got.status);
            return;
         end
         want = predicted_rsp.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("found_number", want.found_number, got.found_number);
         compare_field("found_length", want.found_length, got.found_length);
         compare_field("found_physical", want.found_physical, got.found_physical);
         compare_field("found_flags", want.found_flags, got.found_flags);
         compare_field("found_offset", want.found_offset, got.found_offset);
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned quiet_cycles = 0;

   region_scoreboard sb = new();

   mmio_region_table_top #(
      .MAX_REGIONS(MAX_ENTRIES),
      .PAGE_BYTES (4096)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type make_request(action_type act, logic [31:0] num,
                                            logic [63:0] len, logic [63:0] phys,
                                            logic [31:0] flags, logic [63:0] qoff,
                                            logic [63:0] qlen);
      req_type r;
      r.action = act;
      r.region_number = num;
      r.region_length = len;
      r.physical_base = phys;
      r.access_flags = flags;
      r.query_offset = qoff;
      r.query_length = qlen;
      return r;
   endfunction

   function automatic logic [63:0] pick_length();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 6) return 64'($urandom_range(5 * 4096));
      if (sel < 8) return rand64();
      case ($urandom_range(4))
         0: return '0;
         1: return PAGE;
         2: return PAGE - 1;
         3: return PAGE + 1;
         default: return '1;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      int unsigned pick;
      int unsigned slot;
      logic [63:0] span_len;
      logic [63:0] lead;
      logic [63:0] rest;
      r = make_request(ACT_NONE, $urandom, rand64(), rand64(), $urandom, rand64(), rand64());
      pick = $urandom_range(99);
      if (pick < 25) begin
         r.action = ACT_ADD;
         r.region_length = pick_length();
         case ($urandom_range(9))
            0, 1, 2, 3, 4: r.region_number = $urandom;
            5, 6, 7: if (sb.used > 0) r.region_number = sb.tbl_number[$urandom_range(sb.used - 1)];
            default: r.region_number = $urandom_range(31);
         endcase
      end else if (pick < 50) begin
         r.action = ACT_FIND_NUM;
         if (sb.used > 0 && $urandom_range(9) < 7) begin
            r.region_number = sb.tbl_number[$urandom_range(sb.used - 1)];
         end
      end else if (pick < 90) begin
         r.action = ACT_FIND_RANGE;
         if (sb.used > 0 && $urandom_range(9) < 7) begin
            // Aim the query inside, just past, or just before a stored span.
            slot = $urandom_range(sb.used - 1);
            span_len = sb.tbl_length[slot];
            if ($urandom_range(3) == 0) lead = '0;
            else if (span_len == '1) lead = rand64();
            else lead = rand64() % (span_len + 1);
            rest = span_len - lead;
            r.query_offset = sb.tbl_offset[slot] + lead;
            case ($urandom_range(4))
               0: r.query_length = '0;
               1: r.query_length = rest;
               2: r.query_length = rest + 1;
               3: begin
                  r.query_offset = sb.tbl_offset[slot] - 1;
                  r.query_length = 64'($urandom_range(8));
               end
               default: r.query_length = (rest == '1) ? rand64() : rand64() % (rest + 1);
            endcase
         end
      end else if (pick >= 95) begin
         r.action = 2'($urandom_range(3));
      end
      return r;
   endfunction

   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic run_directed();
      send_request(make_request(ACT_FIND_NUM, '0, '0, '0, '0, '0, '0));
      send_request(make_request(ACT_FIND_RANGE, '0, '0, '0, '0, '0, '0));
      // Zero length: the cursor does not move.
      send_request(make_request(ACT_ADD, '0, '0, '0, '0, '0, '0));
      send_request(make_request(ACT_ADD, '1, 64'd1, '1, '1, '0, '0));
      send_request(make_request(ACT_ADD, '0, 64'd8, 64'd1, 64'd1, '0, '0));
      send_request(make_request(ACT_ADD, 32'd5, PAGE, 64'h1000, 32'h3, '0, '0));
      send_request(make_request(ACT_ADD, 32'd6, PAGE + 1, 64'h2000, 32'h7, '1, '1));
      send_request(make_request(ACT_FIND_NUM, '1, '1, '1, '1, '1, '1));
      send_request(make_request(ACT_FIND_NUM, 32'h1234, '0, '0, '0, '0, '0));
      send_request(make_request(ACT_FIND_RANGE, '0, '0, '0, '0, PAGE, PAGE));
      send_request(make_request(ACT_FIND_RANGE, '0, '0, '0, '0, PAGE, PAGE + 1));
      // Two entries hold the empty span at zero; the newer one answers.
      send_request(make_request(ACT_FIND_RANGE, '0, '0, '0, '0, '0, '0));
      // Largest length: page rounding wraps to zero, and the entry end wraps below its start.
      send_request(make_request(ACT_ADD, 32'd7, '1, 64'hdead_beef, 32'h8000_0000, '0, '0));
      send_request(make_request(ACT_FIND_RANGE, '0, '0, '0, '0, 64'd16384, '0));
      send_request(make_request(ACT_FIND_RANGE, '0, '0, '0, '0, '1, 64'd1));
      send_request(make_request(ACT_NONE, '1, '1, '1, '1, '1, '1));
      send_request(make_request(ACT_ADD, 32'd8, 64'hffff_ffff_ffff_f001, '0, '0, '0, '0));
      send_request(make_request(ACT_FIND_NUM, 32'd8, '0, '0, '0, '0, '0));
      send_request(make_request(ACT_FIND_RANGE, '0, '0, '0, '0, 64'd8192, 64'd4097));
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) send_request(random_request());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 20;
      rsp_idle_pct = 82;
      run_directed();
      run_random(284);
      send_idle_pct = 82;
      rsp_idle_pct = 20;
      run_random(283);
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(283);
      req_valid <= 1'b0;
      while (sb.predicted_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
